FILE: hdl/tgr_pkg.sv
`default_nettype none

package tgr_pkg;

  // Field widths of the channel words and of the configuration port.
  localparam int OP_W      = 2;
  localparam int CODE_W    = 8;
  localparam int GROW_W    = 4;
  localparam int FONT_W    = 8;
  localparam int DIM_W     = 12;
  localparam int IDX_W     = 24;
  localparam int COLOUR_W  = 32;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 32;

  // Geometry of one drawn character.
  localparam int DRAW_ROWS   = 16;
  localparam int ROW_CNT_W   = 5;
  localparam int GLYPH_WIDTH = 8;
  localparam int LINE_STEP   = 16;

  localparam logic [CODE_W-1:0] NEWLINE_CODE = 8'd10;

  // Reset values of the configuration registers.
  localparam logic [COLOUR_W-1:0] COLOUR_RESET = 32'h00FF_FFFF;
  localparam logic [DIM_W-1:0]    WIDTH_RESET  = 12'd640;
  localparam logic [DIM_W-1:0]    PITCH_RESET  = 12'd640;

  typedef enum logic [OP_W-1:0] {
    OP_DRAW   = 2'd0,
    OP_LOAD   = 2'd1,
    OP_CURSOR = 2'd2
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DRAW_COLOUR    = 2'd0,
    REG_SCREEN_WIDTH   = 2'd1,
    REG_SCANLINE_PITCH = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [COLOUR_W-1:0] colour;
    logic [DIM_W-1:0]    width;
    logic [DIM_W-1:0]    pitch;
  } tgr_cfg_t;

endpackage

`default_nettype wire

FILE: hdl/tgr_in_if.sv
`default_nettype none

interface tgr_in_if;
  import tgr_pkg::*;

  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     operation;
  logic [CODE_W-1:0]   char_code;
  logic [GROW_W-1:0]   glyph_row;
  logic [FONT_W-1:0]   font_bits;
  logic [DIM_W-1:0]    new_cursor_x;
  logic [DIM_W-1:0]    new_cursor_y;

  modport source (
    output valid, operation, char_code, glyph_row, font_bits, new_cursor_x, new_cursor_y,
    input  ready
  );

  modport sink (
    input  valid, operation, char_code, glyph_row, font_bits, new_cursor_x, new_cursor_y,
    output ready
  );

endinterface

`default_nettype wire

FILE: hdl/tgr_out_if.sv
`default_nettype none

interface tgr_out_if;
  import tgr_pkg::*;

  logic                valid;
  logic                ready;
  logic [IDX_W-1:0]    pixel_index;
  logic [FONT_W-1:0]   row_mask;
  logic [COLOUR_W-1:0] pixel_colour;
  logic                last_row;

  modport source (
    output valid, pixel_index, row_mask, pixel_colour, last_row,
    input  ready
  );

  modport sink (
    input  valid, pixel_index, row_mask, pixel_colour, last_row,
    output ready
  );

endinterface

`default_nettype wire

FILE: hdl/tgr_font_mem.sv
`default_nettype none

module tgr_font_mem
  import tgr_pkg::*;
#(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [AW-1:0]     waddr_i,
  input  wire logic [FONT_W-1:0] wdata_i,
  input  wire logic              re_i,
  input  wire logic [AW-1:0]     raddr_i,
  output      logic [FONT_W-1:0] rdata_o
);

  logic [FONT_W-1:0] mem [DEPTH];
  logic [FONT_W-1:0] rdata_q;

  // Glyph rows are written one at a time; the read word holds until the next read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: hdl/tgr_draw_seq.sv
`default_nettype none

module tgr_draw_seq
  import tgr_pkg::*;
#(
  parameter int GLYPH_ROWS  = 16,
  parameter int GLYPH_COUNT = 256,
  parameter int COORD_BITS  = 12,
  parameter int AW          = 12
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  tgr_in_if.sink                 in_word,
  tgr_out_if.source              out_word,
  input  wire tgr_cfg_t          cfg_i,
  output      logic              mem_we_o,
  output      logic [AW-1:0]     mem_waddr_o,
  output      logic [FONT_W-1:0] mem_wdata_o,
  output      logic              mem_re_o,
  output      logic [AW-1:0]     mem_raddr_o,
  input  wire logic [FONT_W-1:0] mem_rdata_i
);

  localparam int GW     = (GLYPH_COUNT > 1) ? $clog2(GLYPH_COUNT) : 1;
  localparam int MOD_W  = ((GW > CODE_W) ? GW : CODE_W) + 1;
  localparam int CMP_W  = (COORD_BITS + 2 > DIM_W) ? COORD_BITS + 2 : DIM_W;
  localparam int PROD_W = COORD_BITS + DIM_W;

  localparam logic [CMP_W-1:0]     CoordMax   = CMP_W'((1 << COORD_BITS) - 1);
  localparam logic [ROW_CNT_W:0]   GlyphRowsW = (ROW_CNT_W + 1)'(GLYPH_ROWS);
  localparam logic [MOD_W-1:0]     GlyphCntW  = MOD_W'(GLYPH_COUNT);
  localparam logic [ROW_CNT_W-1:0] RowsEnd    = ROW_CNT_W'(DRAW_ROWS);
  localparam logic [ROW_CNT_W-1:0] RowsLast   = ROW_CNT_W'(DRAW_ROWS - 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_BASE = 2'd2;
  localparam logic [1:0] ST_ROWS = 2'd3;

  logic [1:0]            state_q, state_d;
  logic [COORD_BITS-1:0] col_q, col_d;
  logic [COORD_BITS-1:0] line_q, line_d;
  logic [AW-1:0]         glyph_base_q;
  logic [IDX_W-1:0]      prod_q;
  logic [IDX_W-1:0]      row_idx_q;
  logic [ROW_CNT_W-1:0]  issue_row_q;
  logic                  pend_q, pend_zero_q, pend_last_q;

  logic                  ov_q;
  logic [IDX_W-1:0]      out_idx_q;
  logic [FONT_W-1:0]     out_mask_q;
  logic [COLOUR_W-1:0]   out_colour_q;
  logic                  out_last_q;

  logic                  in_acc, out_free, load_out, issue, row_in_glyph;
  logic                  is_draw, is_newline, grow_ok;
  logic [MOD_W-1:0]      code_m, glyph_m;
  logic [AW-1:0]         glyph_base_c;
  logic [PROD_W-1:0]     prod_c;
  logic [CMP_W-1:0]      line_step_c, line_next_c, col8_c, nx_c, ny_c;
  logic                  wrap_c;

  // Handshake on both sides.
  assign in_word.ready = (state_q == ST_IDLE);
  assign in_acc        = in_word.valid && in_word.ready;
  assign out_free      = !ov_q || out_word.ready;
  assign load_out      = pend_q && out_free;

  assign is_draw    = (in_word.operation == OP_DRAW);
  assign is_newline = (in_word.char_code == NEWLINE_CODE);

  // Glyph number: the code, less the glyph count once if it reaches that count.
  assign code_m       = MOD_W'(in_word.char_code);
  assign glyph_m      = (code_m >= GlyphCntW) ? code_m - GlyphCntW : code_m;
  assign glyph_base_c = AW'(glyph_m) * AW'(GLYPH_ROWS);
  assign grow_ok      = ((ROW_CNT_W + 1)'(in_word.glyph_row) < GlyphRowsW);

  // Font loads write straight into the store.
  assign mem_we_o    = in_acc && (in_word.operation == OP_LOAD) && grow_ok;
  assign mem_waddr_o = glyph_base_c + AW'(in_word.glyph_row);
  assign mem_wdata_o = in_word.font_bits;

  // A row read is issued only when the previous read word can move on.
  assign row_in_glyph = ((ROW_CNT_W + 1)'(issue_row_q) < GlyphRowsW);
  assign issue        = (state_q == ST_ROWS) && (issue_row_q != RowsEnd)
                        && (!pend_q || load_out);
  assign mem_re_o     = issue && row_in_glyph;
  assign mem_raddr_o  = glyph_base_q + AW'(issue_row_q);

  // Cursor arithmetic, saturating at the largest coordinate.
  assign prod_c      = PROD_W'(line_q) * PROD_W'(cfg_i.pitch);
  assign line_step_c = CMP_W'(line_q) + CMP_W'(LINE_STEP);
  assign line_next_c = (line_step_c > CoordMax) ? CoordMax : line_step_c;
  assign col8_c      = CMP_W'(col_q) + CMP_W'(GLYPH_WIDTH);
  assign wrap_c      = (col8_c + CMP_W'(GLYPH_WIDTH) > CMP_W'(cfg_i.width))
                       || (col8_c > CoordMax);
  assign nx_c        = CMP_W'(in_word.new_cursor_x);
  assign ny_c        = CMP_W'(in_word.new_cursor_y);

  // Next cursor and sequencer state.
  always_comb begin
    state_d = state_q;
    col_d   = col_q;
    line_d  = line_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_word.operation == OP_CURSOR) begin
            col_d  = (nx_c > CoordMax) ? '1 : COORD_BITS'(nx_c);
            line_d = (ny_c > CoordMax) ? '1 : COORD_BITS'(ny_c);
          end else if (is_draw && is_newline) begin
            col_d  = '0;
            line_d = COORD_BITS'(line_next_c);
          end else if (is_draw) begin
            state_d = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        state_d = ST_BASE;
      end
      ST_BASE: begin
        state_d = ST_ROWS;
        if (wrap_c) begin
          col_d  = '0;
          line_d = COORD_BITS'(line_next_c);
        end else begin
          col_d = COORD_BITS'(col8_c);
        end
      end
      ST_ROWS: begin
        if ((issue_row_q == RowsEnd) && (!pend_q || load_out)) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      col_q       <= '0;
      line_q      <= '0;
      issue_row_q <= '0;
      pend_q      <= 1'b0;
      ov_q        <= 1'b0;
    end else begin
      state_q <= state_d;
      col_q   <= col_d;
      line_q  <= line_d;
      if (in_acc) begin
        issue_row_q <= '0;
      end else if (issue) begin
        issue_row_q <= issue_row_q + ROW_CNT_W'(1);
      end
      if (issue) begin
        pend_q <= 1'b1;
      end else if (load_out) begin
        pend_q <= 1'b0;
      end
      if (load_out) begin
        ov_q <= 1'b1;
      end else if (out_word.ready) begin
        ov_q <= 1'b0;
      end
    end
  end

  // Datapath registers: glyph base, product, index walk, row flags and output word.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      glyph_base_q <= glyph_base_c;
    end
    if (state_q == ST_MUL) begin
      prod_q <= IDX_W'(prod_c);
    end
    if (state_q == ST_BASE) begin
      row_idx_q <= prod_q + IDX_W'(col_q);
    end else if (load_out) begin
      row_idx_q <= row_idx_q + IDX_W'(cfg_i.pitch);
    end
    if (issue) begin
      pend_zero_q <= !row_in_glyph;
      pend_last_q <= (issue_row_q == RowsLast);
    end
    if (load_out) begin
      out_idx_q    <= row_idx_q;
      out_mask_q   <= pend_zero_q ? '0 : mem_rdata_i;
      out_colour_q <= cfg_i.colour;
      out_last_q   <= pend_last_q;
    end
  end

  assign out_word.valid        = ov_q;
  assign out_word.pixel_index  = out_idx_q;
  assign out_word.row_mask     = out_mask_q;
  assign out_word.pixel_colour = out_colour_q;
  assign out_word.last_row     = out_last_q;

  // A pending read word is never overwritten before it reaches the output register.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_q && !out_free) |-> !mem_re_o)
    else $error("font read issued over a pending row");

  // The sequencer only returns to idle with no row left in flight.
  a_idle_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !pend_q)
    else $error("row pending while idle");

  // A drawn glyph always starts the index setup.
  a_draw_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && is_draw && !is_newline) |=> (state_q == ST_MUL))
    else $error("draw word did not start a glyph");

  // Rows are only issued while a glyph is being drawn and rows remain.
  a_issue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_re_o |-> ((state_q == ST_ROWS) && (issue_row_q != RowsEnd)))
    else $error("font read outside a glyph");

endmodule

`default_nettype wire

FILE: hdl/text_glyph_row_renderer.sv
`default_nettype none

// Channel    Direction  Word contents
// in_word    sink       operation, char_code, glyph_row, font_bits, new_cursor_x/y
// out_word   source     pixel_index, row_mask, pixel_colour, last_row
// cfg_*      input      write enable, register index, write data (no read-back)
//
// A font load, a cursor set or a newline leaves the input open. A drawn character closes the
// input after it is accepted for one multiply, one add for the start index, sixteen glyph
// rows at one per cycle from the single font read port while the output does not stall,
// and moving the last row out; a new draw is accepted only once the previous one is done.
// The first row reaches the output register after the multiply, the add and the font read.
// Reset zeroes the cursor and sets the configuration to its reset values; the font store is not cleared.
// A stalled output holds its row; one more row may be read and held pending, and
// later font reads wait; each stall lengthens the draw.

module text_glyph_row_renderer
  import tgr_pkg::*;
#(
  parameter int GLYPH_ROWS  = 16,
  parameter int GLYPH_COUNT = 256,
  parameter int COORD_BITS  = 12
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  tgr_in_if.sink                     in_word,
  tgr_out_if.source                  out_word,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int DEPTH = GLYPH_COUNT * GLYPH_ROWS;
  localparam int AW    = $clog2(DEPTH);

  tgr_cfg_t          cfg_q;
  logic              mem_we, mem_re;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  logic [FONT_W-1:0] mem_wdata, mem_rdata;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.colour <= COLOUR_RESET;
      cfg_q.width  <= WIDTH_RESET;
      cfg_q.pitch  <= PITCH_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_DRAW_COLOUR:    cfg_q.colour <= cfg_data_i;
        REG_SCREEN_WIDTH:   cfg_q.width  <= cfg_data_i[DIM_W-1:0];
        REG_SCANLINE_PITCH: cfg_q.pitch  <= cfg_data_i[DIM_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Font store.
  tgr_font_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_font_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Cursor and row sequencer.
  tgr_draw_seq #(
    .GLYPH_ROWS  (GLYPH_ROWS),
    .GLYPH_COUNT (GLYPH_COUNT),
    .COORD_BITS  (COORD_BITS),
    .AW          (AW)
  ) u_draw_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_word     (in_word),
    .out_word    (out_word),
    .cfg_i       (cfg_q),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

endmodule

`default_nettype wire
